@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mi3_pkg.sv @@
`timescale 1ns / 1ps
package mi3_pkg;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t ST_GENERAL  = 2'd0;
	localparam status_t ST_AFFINE   = 2'd1;
	localparam status_t ST_SINGULAR = 2'd2;

	// Index of one matrix element, row-major.
	typedef logic [3:0] elem_idx_t;

	// Cofactor products: cofactor i is product 2i minus product 2i+1.
	localparam int NUM_PROD = 18;
	localparam elem_idx_t PROD_A [NUM_PROD] = '{
		4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
		4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
	localparam elem_idx_t PROD_B [NUM_PROD] = '{
		4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
		4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

endpackage

@@ hdl/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
// Fixed-point 3x3 matrix inverse, one matrix per request.
// The input channel takes the nine entries a00..a22 (signed, FRAC_BITS fraction
// bits) with in_valid; the block pushes back with in_stall. The output channel
// returns r00..r22, status (general, affine or singular) and saturated with
// out_valid; the receiver pushes back with out_stall.
// A matrix whose bottom row is within tolerance of (0,0,1) takes the affine
// path; a determinant at or below tolerance gives status singular and zeros.
// The user must write the tolerance register through cfg_we / cfg_wdata only
// while idle; the block itself does not enforce this. Five stages of products,
// cofactors, determinant and operand setup come first, then COEF_WIDTH + 2
// divider stages (overflow check, then one quotient bit each), then the saturating
// output register. A new request is taken every cycle while in_stall is low.
// Each stage moves forward whenever the stage after it is empty or moving, so
// out_stall only halts items that have nowhere to go; bubbles are squeezed out
// and nothing is dropped or repeated. in_stall rises only when every stage is
// full and the output is held.
// Reset empties the pipeline and sets the tolerance to one least significant bit.
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [30:0]                  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COEF_WIDTH-1:0] a00,
	input  logic signed [COEF_WIDTH-1:0] a01,
	input  logic signed [COEF_WIDTH-1:0] a02,
	input  logic signed [COEF_WIDTH-1:0] a10,
	input  logic signed [COEF_WIDTH-1:0] a11,
	input  logic signed [COEF_WIDTH-1:0] a12,
	input  logic signed [COEF_WIDTH-1:0] a20,
	input  logic signed [COEF_WIDTH-1:0] a21,
	input  logic signed [COEF_WIDTH-1:0] a22,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COEF_WIDTH-1:0] r00,
	output logic signed [COEF_WIDTH-1:0] r01,
	output logic signed [COEF_WIDTH-1:0] r02,
	output logic signed [COEF_WIDTH-1:0] r10,
	output logic signed [COEF_WIDTH-1:0] r11,
	output logic signed [COEF_WIDTH-1:0] r12,
	output logic signed [COEF_WIDTH-1:0] r20,
	output logic signed [COEF_WIDTH-1:0] r21,
	output logic signed [COEF_WIDTH-1:0] r22,
	output logic [1:0]                   status,
	output logic                         saturated
);

	localparam int W     = COEF_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int PW    = 2 * W;
	localparam int AW    = 2 * W + 1;
	localparam int HW    = W + 1;
	localparam int D3W   = 3 * W + 4;
	localparam int EW    = ((W > F + 1) ? W : F + 1) + 2;
	localparam int TCW   = ((EW > 31) ? EW : 31) + 1;
	localparam int VW    = ((AW > W + F + 1) ? AW : W + F + 1) + 1;
	localparam int NW    = VW + 2 * F;
	localparam int DSW   = ((D3W > AW + F) ? D3W : AW + F) + 1;
	localparam int CW    = ((DSW > 31 + 2 * F) ? DSW : 31 + 2 * F) + 1;
	localparam int QW    = W + 1;
	localparam int DST   = QW + 1;
	localparam int S_DIV = 5;
	localparam int NS    = DST + 6;
	localparam int S_OUT = NS - 1;

	localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;
	localparam logic        ONE_SAT = (F >= W - 1);
	localparam logic [W-1:0] ONE_VAL = (F >= W - 1) ? {1'b0, {(W-1){1'b1}}} : (W'(1) << F);
	localparam logic [QW-1:0] LIM = QW'(1) << (W - 1);

	// Round-to-range of one quotient: returns {clipped, value}.
	function automatic logic [W:0] clamp_q(logic [QW-1:0] q, logic neg);
		logic [QW-1:0] m;
		logic          s;
		if (neg) begin
			s = (q > LIM);
			m = s ? LIM : q;
			return {s, W'(QW'(-m))};
		end
		s = (q > LIM - 1'b1);
		m = s ? (LIM - 1'b1) : q;
		return {s, m[W-1:0]};
	endfunction

	logic [30:0]   tol_q;
	logic [NS-1:0] v_q;
	logic [NS-1:0] en_c;

	logic signed [W-1:0] a_in [9];

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 31'd1;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Stage enables: a stage loads when it is empty or its successor loads.
	always_comb begin
		en_c[NS-1] = !v_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			en_c[k] = !v_q[k] || en_c[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en_c[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en_c[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !en_c[0];
	assign out_valid = v_q[NS-1];

	assign a_in[0] = a00;
	assign a_in[1] = a01;
	assign a_in[2] = a02;
	assign a_in[3] = a10;
	assign a_in[4] = a11;
	assign a_in[5] = a12;
	assign a_in[6] = a20;
	assign a_in[7] = a21;
	assign a_in[8] = a22;

	// Stage 1: cofactor products and the affine bottom-row test.
	logic signed [PW-1:0] p_s1 [NUM_PROD];
	logic signed [W-1:0]  a_s1 [5];
	logic                 aff_s1;

	logic signed [W:0]    e20_c, e21_c;
	logic [W:0]           abs20_c, abs21_c;
	logic signed [EW-1:0] d22_c;
	logic [EW-1:0]        abs22_c;
	logic                 aff_c;

	always_comb begin
		e20_c   = HW'(a20);
		e21_c   = HW'(a21);
		abs20_c = e20_c[W] ? -e20_c : e20_c;
		abs21_c = e21_c[W] ? -e21_c : e21_c;
		d22_c   = EW'(a22) - ONE_E;
		abs22_c = d22_c[EW-1] ? -d22_c : d22_c;
		aff_c   = (TCW'(abs20_c) <= TCW'(tol_q)) && (TCW'(abs21_c) <= TCW'(tol_q)) &&
			(TCW'(abs22_c) <= TCW'(tol_q));
	end

	always_ff @(posedge clk) begin
		if (en_c[0]) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				p_s1[k] <= a_in[PROD_A[k]] * a_in[PROD_B[k]];
			end
			for (int k = 0; k < 5; k++) begin
				a_s1[k] <= a_in[k];
			end
			aff_s1 <= aff_c;
		end
	end

	// Stage 2: cofactors with their signs.
	logic signed [AW-1:0] adj_s2 [9];
	logic signed [W-1:0]  a_s2 [5];
	logic                 aff_s2;

	always_ff @(posedge clk) begin
		if (en_c[1]) begin
			for (int i = 0; i < 9; i++) begin
				adj_s2[i] <= AW'(p_s1[2*i]) - AW'(p_s1[2*i+1]);
			end
			a_s2   <= a_s1;
			aff_s2 <= aff_s1;
		end
	end

	// Stage 3: determinant partial products, cofactor split in two halves.
	logic signed [PW:0]   hi_s3 [3];
	logic signed [PW:0]   lo_s3 [3];
	logic signed [AW-1:0] adj_s3 [9];
	logic signed [W-1:0]  a_s3 [5];
	logic                 aff_s3;

	always_ff @(posedge clk) begin
		if (en_c[2]) begin
			for (int j = 0; j < 3; j++) begin
				hi_s3[j] <= a_s2[j] * $signed(adj_s2[3*j][AW-1:W]);
				lo_s3[j] <= a_s2[j] * $signed({1'b0, adj_s2[3*j][W-1:0]});
			end
			adj_s3 <= adj_s2;
			a_s3   <= a_s2;
			aff_s3 <= aff_s2;
		end
	end

	// Stage 4: full determinant.
	logic signed [D3W-1:0] det_c;
	logic signed [D3W-1:0] det_s4;
	logic signed [AW-1:0]  adj_s4 [9];
	logic signed [W-1:0]   a_s4 [5];
	logic                  aff_s4;

	always_comb begin
		det_c = '0;
		for (int j = 0; j < 3; j++) begin
			det_c = det_c + (D3W'(hi_s3[j]) <<< W) + D3W'(lo_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_c[3]) begin
			det_s4 <= det_c;
			adj_s4 <= adj_s3;
			a_s4   <= a_s3;
			aff_s4 <= aff_s3;
		end
	end

	// Stage 5: path selection, magnitudes, signs and the singular test.
	// The affine operands are scaled up by FRAC_BITS so both paths share one format.
	logic signed [VW-1:0]  vsel_c [9];
	logic [VW-1:0]         vabs_c [9];
	logic signed [DSW-1:0] dsel_c;
	logic [DSW-1:0]        dabs_c;
	logic                  sing_c;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			vsel_c[i] = VW'(adj_s4[i]);
		end
		dsel_c = DSW'(det_s4);
		if (aff_s4) begin
			vsel_c[0] = VW'(a_s4[4]) <<< F;
			vsel_c[1] = -(VW'(a_s4[1]) <<< F);
			vsel_c[3] = -(VW'(a_s4[3]) <<< F);
			vsel_c[4] = VW'(a_s4[0]) <<< F;
			dsel_c    = DSW'(adj_s4[8]) <<< F;
		end
		for (int i = 0; i < 9; i++) begin
			vabs_c[i] = vsel_c[i][VW-1] ? -vsel_c[i] : vsel_c[i];
		end
		dabs_c = dsel_c[DSW-1] ? -dsel_c : dsel_c;
		sing_c = CW'(dabs_c) <= (CW'(tol_q) << (2 * F));
	end

	logic [NW-1:0]  nmag_s5 [9];
	logic           neg_s5 [9];
	logic [DSW-1:0] dmag_s5;
	logic           aff_s5;
	logic           sing_s5;

	always_ff @(posedge clk) begin
		if (en_c[4]) begin
			for (int i = 0; i < 9; i++) begin
				nmag_s5[i] <= {vabs_c[i], {(2*F){1'b0}}};
				neg_s5[i]  <= vsel_c[i][VW-1] ^ dsel_c[DSW-1];
			end
			dmag_s5 <= dabs_c;
			aff_s5  <= aff_s4;
			sing_s5 <= sing_c;
		end
	end

	// Divider lanes, one per result entry.
	logic [QW-1:0] q_c [9];
	logic          qneg_c [9];

	for (genvar i = 0; i < 9; i++) begin : g_lane
		mi3_div #(
			.QW (QW),
			.NW (NW),
			.DW (DSW)
		) u_div (
			.clk     (clk),
			.en      (en_c[S_DIV +: DST]),
			.num     (nmag_s5[i]),
			.den     (dmag_s5),
			.neg_in  (neg_s5[i]),
			.quo     (q_c[i]),
			.neg_out (qneg_c[i])
		);
	end

	// Path flags travel alongside the divider stages.
	logic aff_sd [DST];
	logic sing_sd [DST];

	always_ff @(posedge clk) begin
		if (en_c[S_DIV]) begin
			aff_sd[0]  <= aff_s5;
			sing_sd[0] <= sing_s5;
		end
		for (int j = 1; j < DST; j++) begin
			if (en_c[S_DIV + j]) begin
				aff_sd[j]  <= aff_sd[j-1];
				sing_sd[j] <= sing_sd[j-1];
			end
		end
	end

	// Output stage: saturate and assemble by path.
	logic [W:0]          cl_c [9];
	logic signed [W-1:0] res_c [9];
	status_t             status_c;
	logic                sat_c;
	logic signed [W-1:0] res_q [9];
	status_t             status_q;
	logic                sat_q;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			cl_c[i]  = clamp_q(q_c[i], qneg_c[i]);
			res_c[i] = cl_c[i][W-1:0];
		end
		if (sing_sd[DST-1]) begin
			for (int i = 0; i < 9; i++) begin
				res_c[i] = '0;
			end
			status_c = ST_SINGULAR;
			sat_c    = 1'b0;
		end else if (aff_sd[DST-1]) begin
			res_c[6] = '0;
			res_c[7] = '0;
			res_c[8] = ONE_VAL;
			status_c = ST_AFFINE;
			sat_c    = ONE_SAT;
			for (int i = 0; i < 6; i++) begin
				sat_c = sat_c | cl_c[i][W];
			end
		end else begin
			status_c = ST_GENERAL;
			sat_c    = 1'b0;
			for (int i = 0; i < 9; i++) begin
				sat_c = sat_c | cl_c[i][W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_c[S_OUT]) begin
			res_q    <= res_c;
			status_q <= status_c;
			sat_q    <= sat_c;
		end
	end

	assign r00       = res_q[0];
	assign r01       = res_q[1];
	assign r02       = res_q[2];
	assign r10       = res_q[3];
	assign r11       = res_q[4];
	assign r12       = res_q[5];
	assign r20       = res_q[6];
	assign r21       = res_q[7];
	assign r22       = res_q[8];
	assign status    = status_q;
	assign saturated = sat_q;

endmodule

@@ hdl/mi3_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for one result entry. It returns
// floor((2n + d) / (2d)), which is n / d rounded half away from zero, and
// the value two to the power QW-1 when the quotient does not fit.
// One quotient bit is resolved per stage, with one stage of overflow check ahead.
module mi3_div #(
	parameter int QW = 33,
	parameter int NW = 100,
	parameter int DW = 100
) (
	input  logic          clk,
	input  logic [QW:0]   en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg_in,
	output logic [QW-1:0] quo,
	output logic          neg_out
);

	localparam int ST = QW + 1;
	localparam int RA = ((NW > DW) ? NW : DW) + 2;
	localparam int RB = DW + QW + 1;
	localparam int RW = ((RA > RB) ? RA : RB) + 1;

	logic [RW-1:0] rem_sd [ST];
	logic [DW:0]   den_sd [ST];
	logic [QW-1:0] q_sd   [ST];
	logic          ovf_sd [ST];
	logic          neg_sd [ST];

	logic [RW-1:0] num2_c;
	logic [DW:0]   den2_c;

	// Doubled operands and the overflow check.
	assign num2_c = {{(RW-NW-1){1'b0}}, num, 1'b0} + RW'(den);
	assign den2_c = {den, 1'b0};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_sd[0] <= num2_c;
			den_sd[0] <= den2_c;
			q_sd[0]   <= '0;
			ovf_sd[0] <= (num2_c >= (RW'(den2_c) << QW));
			neg_sd[0] <= neg_in;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 1; j < ST; j++) begin : g_bit
		logic [RW-1:0] t_c;
		logic          take_c;

		assign t_c    = RW'(den_sd[j-1]) << (QW - j);
		assign take_c = !ovf_sd[j-1] && (rem_sd[j-1] >= t_c);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_sd[j] <= take_c ? (rem_sd[j-1] - t_c) : rem_sd[j-1];
				q_sd[j]   <= q_sd[j-1] | (take_c ? (QW'(1) << (QW - j)) : '0);
				den_sd[j] <= den_sd[j-1];
				ovf_sd[j] <= ovf_sd[j-1];
				neg_sd[j] <= neg_sd[j-1];
			end
		end
	end

	assign quo     = ovf_sd[ST-1] ? (QW'(1) << (QW - 1)) : q_sd[ST-1];
	assign neg_out = neg_sd[ST-1];

endmodule

@@ hdl/mi3_chk.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks for the matrix inverse.
module mi3_chk import mi3_pkg::*; #(
	parameter int COEF_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [COEF_WIDTH-1:0] r00,
	input logic signed [COEF_WIDTH-1:0] r01,
	input logic signed [COEF_WIDTH-1:0] r02,
	input logic signed [COEF_WIDTH-1:0] r10,
	input logic signed [COEF_WIDTH-1:0] r11,
	input logic signed [COEF_WIDTH-1:0] r12,
	input logic signed [COEF_WIDTH-1:0] r20,
	input logic signed [COEF_WIDTH-1:0] r21,
	input logic signed [COEF_WIDTH-1:0] r22,
	input logic [1:0]                   status,
	input logic                         saturated
);

	// A held result keeps its valid, r00, r22 and its status.
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(r00) && $stable(r22) && $stable(status), "held result changed")

	// With the output register empty the pipeline always has room.
	`ASSERT_SAME(a_room, !out_valid, !in_stall, "input stalled while output empty")

	// A singular result carries zeros and no saturation.
	`ASSERT_SAME(a_sing_zero, out_valid && status == ST_SINGULAR, r00 == 0 && r01 == 0 && r02 == 0 && r10 == 0 && r11 == 0 && r12 == 0 && r20 == 0 && r21 == 0 && r22 == 0 && !saturated, "singular result not cleared")

	// An affine result has a zero bottom-left pair.
	`ASSERT_SAME(a_aff_row, out_valid && status == ST_AFFINE, r20 == 0 && r21 == 0, "affine bottom row not zero")

endmodule

bind matrix_inverse_3x3 mi3_chk #(.COEF_WIDTH(COEF_WIDTH)) u_mi3_chk (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import mi3_pkg::*;

	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam int NDIR = 15;
	localparam int NRAND = 1100;
	localparam int STALL_LIMIT = 5000;

	typedef logic signed [31:0] coef_t;
	typedef logic signed [255:0] wide_t;
	typedef struct {
		coef_t   r[9];
		status_t st;
		logic    sat;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coef_t a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0;
	coef_t a20 = '0, a21 = '0, a22 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	coef_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic [1:0] status;
	logic saturated;

	logic [30:0] tol_shadow = 31'd1;
	inverse_t pending_inverses[$];
	int mismatch_cnt = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	matrix_inverse_3x3 i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11), .a12(a12),
		.a20(a20), .a21(a21), .a22(a22),
		.out_valid(out_valid), .out_stall(out_stall),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.status(status), .saturated(saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Rounded quotient, ties away from zero, clipped to the 32-bit signed range.
	function automatic coef_t div_round(wide_t num, wide_t den, inout logic sat);
		logic [255:0] nm, dm, q;
		logic neg;
		neg = ((num < 0) != (den < 0)) && (num != 0);
		nm = (num < 0) ? -num : num;
		dm = (den < 0) ? -den : den;
		q = (2 * nm + dm) / (2 * dm);
		if (neg) begin
			if (q > 256'h8000_0000) begin
				q = 256'h8000_0000;
				sat = 1'b1;
			end
			return coef_t'(-q);
		end
		if (q > 256'h7FFF_FFFF) begin
			q = 256'h7FFF_FFFF;
			sat = 1'b1;
		end
		return coef_t'(q);
	endfunction

	function automatic wide_t cross2(wide_t p, wide_t q, wide_t r, wide_t s);
		return p * q - r * s;
	endfunction

	// Exact inverse of one matrix under the current tolerance.
	function automatic inverse_t invert_matrix(coef_t m[9], logic [30:0] tol);
		inverse_t res;
		wide_t e[9];
		wide_t adj[9];
		wide_t det, tolw, d22;
		logic sat;
		sat = 1'b0;
		for (int i = 0; i < 9; i++) begin
			e[i] = m[i];
			res.r[i] = '0;
		end
		res.sat = 1'b0;
		tolw = {225'd0, tol};
		d22 = e[8] - ONE;
		if ((e[6] < 0 ? -e[6] : e[6]) <= tolw && (e[7] < 0 ? -e[7] : e[7]) <= tolw
				&& (d22 < 0 ? -d22 : d22) <= tolw) begin
			// Affine path: invert the 2x2 part and carry the translation.
			det = cross2(e[0], e[4], e[1], e[3]);
			if ((det < 0 ? -det : det) <= (tolw <<< 16)) begin
				res.st = ST_SINGULAR;
				return res;
			end
			res.r[0] = div_round(e[4] <<< 32, det, sat);
			res.r[1] = div_round(-(e[1] <<< 32), det, sat);
			res.r[2] = div_round(-(cross2(e[4], e[2], e[1], e[5]) <<< 16), det, sat);
			res.r[3] = div_round(-(e[3] <<< 32), det, sat);
			res.r[4] = div_round(e[0] <<< 32, det, sat);
			res.r[5] = div_round(cross2(e[3], e[2], e[0], e[5]) <<< 16, det, sat);
			res.r[8] = ONE;
			res.st = ST_AFFINE;
		end else begin
			// General path: adjugate over the full determinant.
			adj[0] = cross2(e[4], e[8], e[5], e[7]);
			adj[1] = -cross2(e[1], e[8], e[2], e[7]);
			adj[2] = cross2(e[1], e[5], e[2], e[4]);
			adj[3] = -cross2(e[3], e[8], e[5], e[6]);
			adj[4] = cross2(e[0], e[8], e[2], e[6]);
			adj[5] = -cross2(e[0], e[5], e[2], e[3]);
			adj[6] = cross2(e[3], e[7], e[4], e[6]);
			adj[7] = -cross2(e[0], e[7], e[1], e[6]);
			adj[8] = cross2(e[0], e[4], e[1], e[3]);
			det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
			if ((det < 0 ? -det : det) <= (tolw <<< 32)) begin
				res.st = ST_SINGULAR;
				return res;
			end
			for (int i = 0; i < 9; i++) res.r[i] = div_round(adj[i] <<< 32, det, sat);
			res.st = ST_GENERAL;
		end
		res.sat = sat;
		return res;
	endfunction

	// Present one request, holding it until the block takes it.
	task automatic send_matrix(coef_t m[9], bit typed, inverse_t typed_want);
		while (!calm && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		{a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_inverses.push_back(typed ? typed_want : invert_matrix(m, tol_shadow));
	endtask

	// Drain the pipeline, then write the tolerance register.
	task automatic set_tolerance(logic [30:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_inverses.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_shadow = value;
	endtask

	function automatic coef_t rand_coef();
		case ($urandom_range(0, 4))
			0: return coef_t'($urandom);
			1: return coef_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			2: return coef_t'($urandom_range(0, 64)) - 32;
			3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return coef_t'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic coef_t near(coef_t centre, logic [30:0] tol);
		int unsigned span;
		span = (tol > 31'd1000) ? 1000 : int'(tol);
		return centre + coef_t'($urandom_range(0, 2 * span)) - coef_t'(span);
	endfunction

	// Request checker and receiver stall generator.
	always @(posedge clk) begin
		inverse_t want, seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.r = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			seen.st = status;
			seen.sat = saturated;
			if (pending_inverses.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				mismatch_cnt++;
			end else begin
				want = pending_inverses.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (seen.r[i] !== want.r[i]) begin
						$display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
							want.r[i], seen.r[i]);
						mismatch_cnt++;
					end
				end
				if (seen.st !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, seen.st);
					mismatch_cnt++;
				end
				if (seen.sat !== want.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, want.sat, seen.sat);
					mismatch_cnt++;
				end
			end
		end
		out_stall <= !calm && ($urandom_range(0, 99) < 24);
	end

	// Watchdog on cycles in which neither channel moves.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL matrix_inverse_3x3");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	coef_t dir_tab [NDIR][9] = '{
		'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, ONE},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
		'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
		'{ONE, 0, 3 * ONE, 0, ONE, -2 * ONE, 0, 0, ONE},
		'{ONE, 2 * ONE, 0, 2 * ONE, 4 * ONE, 0, 0, 0, ONE},
		'{ONE, 0, 0, 0, ONE, 0, ONE / 2, ONE / 4, ONE},
		'{ONE, 0, 0, 0, ONE, 0, 0, 0, 2},
		'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555},
		'{ONE, 0, 0, 0, ONE, 0, 2, 0, ONE},
		'{ONE, 0, 0, 0, ONE, 0, 1, -1, ONE + 1},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000},
		'{0, -ONE, 5 * ONE, ONE, 0, 7 * ONE, 0, 0, ONE},
		'{ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, ONE, ONE, ONE}
	};

	// Stimulus: directed table, then random phases under several tolerances.
	initial begin
		inverse_t want;
		coef_t m[9];
		logic [30:0] tol_list[6];
		bit typed;
		int kind;
		tol_list = '{31'd0, 31'd16, 31'h7FFF_FFFF, 31'd1, 31'd655, 31'd0};
		tol_list[5] = 31'($urandom_range(0, 4096));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int row = 0; row < NDIR; row++) begin
			typed = 1'b1;
			want.r = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
			want.sat = 1'b0;
			case (row)
				0: begin
					want.r = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
					want.st = ST_AFFINE;
				end
				1, 6: want.st = ST_SINGULAR;
				2: begin
					want.r = '{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE};
					want.st = ST_AFFINE;
				end
				default: typed = 1'b0;
			endcase
			send_matrix(dir_tab[row], typed, want);
		end
		for (int phase = 0; phase < 6; phase++) begin
			set_tolerance(tol_list[phase]);
			for (int n = 0; n < NRAND / 6; n++) begin
				calm = (phase == 3 && n >= 20 && n < 140);
				if (phase == 1 && n == 90) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_inverses.size() != 0) @(posedge clk);
				end
				kind = $urandom_range(0, 9);
				for (int i = 0; i < 9; i++) m[i] = rand_coef();
				if (kind < 4) begin
					// Affine transform, bottom row within tolerance.
					m[6] = near(0, tol_shadow);
					m[7] = near(0, tol_shadow);
					m[8] = near(ONE, tol_shadow);
				end else if (kind == 4) begin
					m[6] = 0;
					m[7] = 0;
					m[8] = ONE;
					m[3] = m[0];
					m[4] = m[1];
				end else if (kind == 5) begin
					m[6] = m[0];
					m[7] = m[1];
					m[8] = m[2];
				end
				send_matrix(m, 1'b0, want);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_inverses.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatch_cnt == 0 && pending_inverses.size() == 0) begin
			$display("PASS matrix_inverse_3x3");
		end else begin
			$display("FAIL matrix_inverse_3x3");
		end
		$finish;
	end

endmodule

@@ matrix_inverse_3x3.f @@
+incdir+hdl
hdl/mi3_pkg.sv
hdl/mi3_div.sv
hdl/matrix_inverse_3x3.sv
hdl/mi3_chk.sv
verif/testbench.sv
